>>> sv/swfd_pkg.sv
// ----------------------------------------------------------------------------
// swfd_pkg: shared types and constants of the sync word frame deframer
// Sync word bytes, parse phase codes and the result and status bundles that
// pass between the parser and the top level.
// ----------------------------------------------------------------------------
package swfd_pkg;

   // sync word "sync"
   localparam logic [7:0] SYNC_B0 = 8'h73;
   localparam logic [7:0] SYNC_B1 = 8'h79;
   localparam logic [7:0] SYNC_B2 = 8'h6E;
   localparam logic [7:0] SYNC_B3 = 8'h63;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ID_W   = 32;
   localparam int unsigned LEN_W  = 16;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_SYNC1 = 4'd1,
      PH_SYNC2 = 4'd2,
      PH_SYNC3 = 4'd3,
      PH_ID0   = 4'd4,
      PH_ID1   = 4'd5,
      PH_ID2   = 4'd6,
      PH_ID3   = 4'd7,
      PH_LENHI = 4'd8,
      PH_LENLO = 4'd9,
      PH_DATA  = 4'd10
   } phase_type;

   // one result transaction
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [ID_W-1:0]   sender_id;
      logic [LEN_W-1:0]  frame_length;
      logic              last_byte;
   } result_type;

   // parser state seen by the top level
   typedef struct packed {
      phase_type        phase;
      logic [LEN_W-1:0] length_hold;
      logic [LEN_W-1:0] bytes_left;
   } status_type;

endpackage

>>> sv/swfd_parse.sv
// ----------------------------------------------------------------------------
// swfd_parse: frame parse state machine
// Holds the hunt/header/payload state and, for each byte stepped in, updates
// it and forms the payload result of that byte, if any.
// ----------------------------------------------------------------------------
module swfd_parse
   import swfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] rx_byte,
   output logic              res_valid,
   output result_type        res,
   output status_type        status
);

   phase_type        phase_ff, phase_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [LEN_W-1:0] left_dec;

   // hold the parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         id_ff    <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         id_ff    <= id_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
      end
   end

   assign left_dec = left_ff - LEN_W'(1);

   // advance the phase and form the result
   always_comb begin
      phase_in  = phase_ff;
      id_in     = id_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      res_valid = 1'b0;
      res.payload_byte = rx_byte;
      res.sender_id    = id_ff;
      res.frame_length = len_ff;
      res.last_byte    = (left_dec == '0);
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_B0) phase_in = PH_SYNC1;
         end
         PH_SYNC1: begin
            if (rx_byte == SYNC_B1)      phase_in = PH_SYNC2;
            else if (rx_byte == SYNC_B0) phase_in = PH_SYNC1;
            else                         phase_in = PH_HUNT;
         end
         PH_SYNC2: begin
            phase_in = (rx_byte == SYNC_B2) ? PH_SYNC3 : PH_HUNT;
         end
         PH_SYNC3: begin
            if (rx_byte == SYNC_B3) begin
               id_in    = '0;
               len_in   = '0;
               phase_in = PH_ID0;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_ID0: begin
            id_in    = {rx_byte, 24'h0};
            phase_in = PH_ID1;
         end
         PH_ID1: begin
            id_in    = {id_ff[31:24], rx_byte, id_ff[15:0]};
            phase_in = PH_ID2;
         end
         PH_ID2: begin
            id_in    = {id_ff[31:16], rx_byte, id_ff[7:0]};
            phase_in = PH_ID3;
         end
         PH_ID3: begin
            id_in    = {id_ff[31:8], rx_byte};
            phase_in = PH_LENHI;
         end
         PH_LENHI: begin
            len_in   = {rx_byte, 8'h0};
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            len_in   = {len_ff[15:8], rx_byte};
            left_in  = {len_ff[15:8], rx_byte};
            phase_in = ({len_ff[15:8], rx_byte} != '0) ? PH_DATA : PH_HUNT;
         end
         PH_DATA: begin
            // emit the byte while the count lasts; drop back to hunt at the end
            if (left_ff != '0) begin
               left_in   = left_dec;
               res_valid = 1'b1;
               if (left_dec == '0) phase_in = PH_HUNT;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   assign status.phase       = phase_ff;
   assign status.length_hold = len_ff;
   assign status.bytes_left  = left_ff;

endmodule

>>> sv/sync_word_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_unit: sync word framed byte stream deframer
// Hunts for "sync", reads a 32-bit sender id and a 16-bit length, then gives
// out each payload byte with the id, the length and a last marker.
// ----------------------------------------------------------------------------
// Takes one byte per clock while rsp_ready stays high. Each byte lands in an
// input register, is parsed by a single short step of the frame state
// machine once the result register is free or being drained, and a payload
// byte then appears from the result register. Header bytes, sync bytes and
// bytes of a zero-length frame produce no result transaction.
module sync_word_frame_deframer_unit
   import swfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_payload_byte,
   output logic [ID_W-1:0]   rsp_sender_id,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic              rsp_last_byte
);

   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_vld_ff, out_vld_in;
   result_type        out_ff;
   logic              advance;
   logic              res_valid;
   result_type        res;
   status_type        status;

   // step the parser when the result register is free or being drained
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;

   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !advance);
   assign out_vld_in = advance ? res_valid : (out_vld_ff && !rsp_ready);

   // hold the input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) in_byte_ff <= req_rx_byte;
      if (advance && res_valid)   out_ff     <= res;
   end

   swfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res),
      .status    (status)
   );

   assign rsp_valid        = out_vld_ff;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_sender_id    = out_ff.sender_id;
   assign rsp_frame_length = out_ff.frame_length;
   assign rsp_last_byte    = out_ff.last_byte;

   // a delivered payload byte always belongs to a nonempty frame
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_length != '0)
      else $error("result with zero frame length");

   // in payload phase the remaining count is nonzero and within the length
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      status.phase == PH_DATA |->
         (status.bytes_left != '0) && (status.bytes_left <= status.length_hold))
      else $error("payload count out of range");

   // the last byte of a frame returns the parser to the hunt
   a_last_hunt: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid && res.last_byte |=> status.phase == PH_HUNT)
      else $error("parser did not return to hunt after last byte");

   // a result register cannot fill without a parser step
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff ##1 out_vld_ff |-> $past(advance && res_valid))
      else $error("result appeared without a parse step");

endmodule

>>> tb/sync_word_frame_deframer_unit_tb.sv
// ----------------------------------------------------------------------------
// sync_word_frame_deframer_unit_tb: self-checking bench for the deframer
// Feeds byte streams through the request channel: a short directed table,
// then random well-formed frames mixed with broken sync words and line noise.
// A local frame parser predicts every payload transaction. The response
// monitor compares each one field by field, in order, under several
// idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module sync_word_frame_deframer_unit_tb;
   import swfd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_BYTES  = 30;
   localparam int DIR_ROWS     = 28;
   localparam logic [31:0] SYNC_WORD = {SYNC_B0, SYNC_B1, SYNC_B2, SYNC_B3};
   localparam result_type NO_RSP = '0;

   // one row of the directed table; want is used only when typed is set
   typedef struct {
      logic [BYTE_W-1:0] rx_byte;
      bit                typed;
      result_type        want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [BYTE_W-1:0] rsp_payload_byte;
   logic [ID_W-1:0]   rsp_sender_id;
   logic [LEN_W-1:0]  rsp_frame_length;
   logic              rsp_last_byte;

   // frame parser state of the predictor
   phase_type         frm_phase = PH_HUNT;
   logic [ID_W-1:0]   frm_id    = '0;
   logic [LEN_W-1:0]  frm_len   = '0;
   logic [LEN_W-1:0]  frm_left  = '0;

   result_type        payload_q [$];
   int                error_count   = 0;
   int                cycle_count   = 0;
   int                bytes_sent    = 0;
   int                req_idle_pct  = 0;
   int                rsp_stall_pct = 0;
   bit                long_hold_req = 1'b0;

   // sync with a repeated 's', extreme id, one-byte payload; mismatch on 'n';
   // all-zero id with a zero-length frame
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{SYNC_B0, 1'b0, NO_RSP}, '{SYNC_B0, 1'b0, NO_RSP},
      '{SYNC_B1, 1'b0, NO_RSP}, '{SYNC_B2, 1'b0, NO_RSP},
      '{SYNC_B3, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP}, '{8'hFF, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, NO_RSP}, '{8'hFF, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h01, 1'b0, NO_RSP},
      '{8'hFF, 1'b1, '{8'hFF, 32'hFFFF_FFFF, 16'h0001, 1'b1}},
      '{SYNC_B0, 1'b0, NO_RSP}, '{SYNC_B1, 1'b0, NO_RSP},
      '{SYNC_B0, 1'b0, NO_RSP}, '{SYNC_B1, 1'b0, NO_RSP},
      '{SYNC_B2, 1'b0, NO_RSP}, '{SYNC_B3, 1'b0, NO_RSP},
      '{SYNC_B0, 1'b0, NO_RSP}, '{SYNC_B1, 1'b0, NO_RSP},
      '{SYNC_B2, 1'b0, NO_RSP}, '{SYNC_B3, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP},
      '{8'h00, 1'b0, NO_RSP}, '{8'h00, 1'b0, NO_RSP}
   };

   sync_word_frame_deframer_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_sender_id    (rsp_sender_id),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last_byte    (rsp_last_byte)
   );

   always #4 clock = ~clock;

   // Advance the frame parser by one byte; got is set when a payload
   // transaction results.
   function automatic void deframe_byte(input logic [BYTE_W-1:0] b, output bit got,
                                        output result_type res);
      got = 1'b0;
      res = '0;
      case (frm_phase)
         PH_HUNT: begin
            if (b == SYNC_B0) frm_phase = PH_SYNC1;
         end
         PH_SYNC1: begin
            // a repeated 's' keeps the partial match
            if (b == SYNC_B1) frm_phase = PH_SYNC2;
            else if (b != SYNC_B0) frm_phase = PH_HUNT;
         end
         PH_SYNC2: frm_phase = (b == SYNC_B2) ? PH_SYNC3 : PH_HUNT;
         PH_SYNC3: begin
            if (b == SYNC_B3) begin
               frm_id    = '0;
               frm_len   = '0;
               frm_phase = PH_ID0;
            end else begin
               frm_phase = PH_HUNT;
            end
         end
         PH_ID0: begin
            frm_id    = {b, 24'h0};
            frm_phase = PH_ID1;
         end
         PH_ID1: begin
            frm_id[23:16] = b;
            frm_phase     = PH_ID2;
         end
         PH_ID2: begin
            frm_id[15:8] = b;
            frm_phase    = PH_ID3;
         end
         PH_ID3: begin
            frm_id[7:0] = b;
            frm_phase   = PH_LENHI;
         end
         PH_LENHI: begin
            frm_len   = {b, 8'h0};
            frm_phase = PH_LENLO;
         end
         PH_LENLO: begin
            frm_len[7:0] = b;
            frm_left     = {frm_len[15:8], b};
            frm_phase    = (frm_left != '0) ? PH_DATA : PH_HUNT;
         end
         PH_DATA: begin
            if (frm_left != '0) begin
               frm_left         = frm_left - 1'b1;
               res.payload_byte = b;
               res.sender_id    = frm_id;
               res.frame_length = frm_len;
               res.last_byte    = (frm_left == '0);
               got              = 1'b1;
            end
            if (frm_left == '0) frm_phase = PH_HUNT;
         end
         default: frm_phase = PH_HUNT;
      endcase
   endfunction

   // Offer one byte, after a random idle gap, and hold it until accepted.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit typed = 1'b0,
                            input result_type want = '0);
      int         gap;
      bit         got;
      result_type res;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      deframe_byte(b, got, res);
      if (typed) payload_q.push_back(want);
      else if (got) payload_q.push_back(res);
   endtask

   // Send one random unit: mostly a well-formed frame, else a broken sync
   // word or a burst of line noise.
   task automatic send_random_unit(input bit big);
      int              kind;
      int              cut;
      int              k;
      int              len;
      logic [ID_W-1:0] id;
      kind = $urandom_range(99);
      if (!big && kind >= 75) begin
         if (kind < 90) begin
            // break the sync word after 1..3 good bytes
            cut = $urandom_range(1, 3);
            for (k = 0; k < cut; k++) send_byte(SYNC_WORD[31-8*k -: 8]);
            send_byte($urandom_range(1) ? SYNC_B0 : 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
         end
         return;
      end
      if ($urandom_range(3) == 0) send_byte(SYNC_B0);
      for (k = 0; k < 4; k++) send_byte(SYNC_WORD[31-8*k -: 8]);
      id = $urandom;
      case ($urandom_range(7))
         0: id = '0;
         1: id = '1;
         default: ;
      endcase
      for (k = 0; k < 4; k++) send_byte(id[31-8*k -: 8]);
      if (big) len = $urandom_range(256, 280);
      else if ($urandom_range(9) == 0) len = 0;
      else len = $urandom_range(1, 12);
      send_byte(8'(len >> 8));
      send_byte(8'(len));
      // salt the payload with sync bytes; they must pass through as data
      for (k = 0; k < len; k++) begin
         if ($urandom_range(3) == 0) send_byte(SYNC_WORD[31-8*$urandom_range(3) -: 8]);
         else send_byte(8'($urandom_range(255)));
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Compare each accepted response transaction with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (payload_q.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual byte %0h",
                     $time, rsp_payload_byte);
            error_count++;
         end else begin
            want = payload_q.pop_front();
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
            check_field("sender_id", want.sender_id, rsp_sender_id);
            check_field("frame_length", 32'(want.frame_length), 32'(rsp_frame_length));
            check_field("last_byte", 32'(want.last_byte), 32'(rsp_last_byte));
         end
      end
   end

   // Drive rsp_ready: random stalls, or one long hold on request.
   initial begin : rsp_side
      int hold;
      rsp_ready = 1'b0;
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      int  idx;
      int  mode;
      int  start;
      bit  paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (idx = 0; idx < DIR_ROWS; idx++)
         send_byte(dir_rows[idx].rx_byte, dir_rows[idx].typed, dir_rows[idx].want);

      // random phases: no idling, sender idle, receiver stall, both light
      paused = 1'b0;
      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 83; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 83; end
            default: begin req_idle_pct = 10; rsp_stall_pct = 10; end
         endcase
         start = bytes_sent;
         if (mode == 0) begin
            // hold the receiver while a long frame streams in to fill the block
            long_hold_req = 1'b1;
            send_random_unit(1'b1);
         end
         while (bytes_sent - start < PHASE_BYTES) begin
            if (mode == 2 && !paused && bytes_sent - start >= PHASE_BYTES / 2) begin
               // pause the sender until every prediction is consumed
               paused = 1'b1;
               req_valid <= 1'b0;
               @(posedge clock);
               while (payload_q.size() != 0) @(posedge clock);
            end
            send_random_unit(1'b0);
         end
      end

      // drain
      req_valid <= 1'b0;
      while (payload_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> sync_word_frame_deframer_unit.f
sv/swfd_pkg.sv
sv/swfd_parse.sv
sv/sync_word_frame_deframer_unit.sv
tb/sync_word_frame_deframer_unit_tb.sv
